// ----- src/ddws_pkg.sv -----
// Shared types and constants for the differential-drive wheel speed block.
package ddws_pkg;

  localparam int unsigned SPEED_W   = 32;
  localparam int unsigned CFG_W     = 31;
  localparam int unsigned CFG_IDX_W = 2;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_TRACK      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_WHEEL_RADIUS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_WHEEL_SPEED  = 2'd2;

  // Register reset values.
  localparam logic [CFG_W-1:0] WHEEL_TRACK_RST      = 31'd65536;
  localparam logic [CFG_W-1:0] INV_WHEEL_RADIUS_RST = 31'd65536;
  localparam logic [CFG_W-1:0] MAX_WHEEL_SPEED_RST  = 31'd0;

  // Pipeline geometry: front stages, one restoring step per quotient bit, then
  // the initial divider stage and the output stage.
  localparam int unsigned PRE_STAGES = 5;
  localparam int unsigned DIV_STEPS  = 32;
  localparam int unsigned NUM_STAGES = PRE_STAGES + DIV_STEPS + 2;

  typedef struct packed {
    logic signed [SPEED_W-1:0] forward_speed;
    logic signed [SPEED_W-1:0] yaw_rate;
  } in_beat_t;

  typedef struct packed {
    logic signed [SPEED_W-1:0] left_wheel_speed;
    logic signed [SPEED_W-1:0] right_wheel_speed;
    logic                      was_scaled;
  } out_beat_t;

endpackage

// ----- src/differential_drive_wheel_speeds.sv -----
// Differential-drive inverse kinematics: chassis command in, wheel speeds out.
//
//   channel | direction | handshake            | beat
//   --------+-----------+----------------------+------------------------------------
//   in_     | in        | in_valid / in_stall   | forward_speed, yaw_rate (Q16.16)
//   out_    | out       | out_valid / out_stall | left/right wheel speed, was_scaled
//   cfg_    | in        | cfg_valid / cfg_ready | cfg_index, cfg_data (31 bits)
//
// One command enters per cycle while in_stall is low; its result is offered from the last
// of 39 register stages, the first loaded at the accepting edge.
// Most of that depth is the 32-step restoring divider that applies the speed limit.
// Reset (rst_n low, synchronous) empties the pipeline and loads register defaults.
// A stalled result moves to a skid register; the pipeline then holds until it drains.
// in_stall is a register output and never depends on out_stall in the same cycle.
module differential_drive_wheel_speeds (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  ddws_pkg::in_beat_t                      in_data,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output ddws_pkg::out_beat_t                     out_data,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [ddws_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [ddws_pkg::CFG_W-1:0]              cfg_data
);

  localparam int unsigned LAST    = ddws_pkg::NUM_STAGES - 1;
  localparam int unsigned DV_BASE = ddws_pkg::PRE_STAGES;
  localparam int unsigned DV_LAST = DV_BASE + ddws_pkg::DIV_STEPS;

  // One divider stage: remainder, dividend/quotient shift word and divisor.
  typedef struct packed {
    logic [60:0] rem_l;
    logic [31:0] qd_l;
    logic [60:0] rem_r;
    logic [31:0] qd_r;
    logic [60:0] dvsr;
    logic        neg_l;
    logic        neg_r;
    logic        scaled;
  } dv_t;

  // Configuration registers.
  logic [ddws_pkg::CFG_W-1:0] track_r;
  logic [ddws_pkg::CFG_W-1:0] inv_r;
  logic [ddws_pkg::CFG_W-1:0] max_r;

  // Pipeline control.
  logic [ddws_pkg::NUM_STAGES-1:0] vld_r;
  logic [ddws_pkg::NUM_STAGES-1:0] vld_nxt;
  logic                            en;
  logic                            skid_vld_r;
  logic                            skid_vld_nxt;
  logic                            skid_load;
  ddws_pkg::out_beat_t             skid_r;

  // Stage 1: yaw term.
  logic [31:0] s1_vx_r;
  logic [63:0] s1_turn_r;
  logic [63:0] s1_turn_nxt;

  // Stage 2: signed linear terms and their magnitudes.
  logic [63:0] s2_base;
  logic [63:0] s2_l_pos;
  logic [63:0] s2_l_ngv;
  logic [63:0] s2_r_pos;
  logic [63:0] s2_r_ngv;
  logic [62:0] s2_lmag_r;
  logic [62:0] s2_lmag_nxt;
  logic [62:0] s2_rmag_r;
  logic [62:0] s2_rmag_nxt;
  logic        s2_lneg_r;
  logic        s2_rneg_r;

  // Stage 3: partial products with the reciprocal radius.
  logic [62:0] s3_l_lo_r;
  logic [62:0] s3_l_lo_nxt;
  logic [61:0] s3_l_hi_r;
  logic [61:0] s3_l_hi_nxt;
  logic [62:0] s3_r_lo_r;
  logic [62:0] s3_r_lo_nxt;
  logic [61:0] s3_r_hi_r;
  logic [61:0] s3_r_hi_nxt;
  logic        s3_lneg_r;
  logic        s3_rneg_r;

  // Stage 4: wheel speed magnitudes.
  logic [61:0] s4_l_sum;
  logic [61:0] s4_r_sum;
  logic [60:0] s4_lmag_r;
  logic [60:0] s4_rmag_r;
  logic        s4_lneg_r;
  logic        s4_rneg_r;

  // Stage 5: limit test, clamped magnitudes and partial products with the limit.
  logic [60:0] s5_max61;
  logic [60:0] s5_top_r;
  logic [60:0] s5_top_nxt;
  logic        s5_scale_r;
  logic        s5_scale_nxt;
  logic [31:0] s5_l_sat_r;
  logic [31:0] s5_r_sat_r;
  logic [62:0] s5_l_plo_r;
  logic [62:0] s5_l_plo_nxt;
  logic [59:0] s5_l_phi_r;
  logic [59:0] s5_l_phi_nxt;
  logic [62:0] s5_r_plo_r;
  logic [62:0] s5_r_plo_nxt;
  logic [59:0] s5_r_phi_r;
  logic [59:0] s5_r_phi_nxt;
  logic        s5_lneg_r;
  logic        s5_rneg_r;

  // Divider stages: entry 0 holds the loaded dividend, entry i the state after step i.
  logic [91:0] dv_prod_l;
  logic [91:0] dv_prod_r;
  logic [91:0] dv_dend_l;
  logic [91:0] dv_dend_r;
  dv_t         dv_r   [0:ddws_pkg::DIV_STEPS];
  dv_t         dv_nxt [0:ddws_pkg::DIV_STEPS];

  // Output stage.
  ddws_pkg::out_beat_t so_r;
  ddws_pkg::out_beat_t so_nxt;

  // Clamp a magnitude so that the signed result fits in 32 bits.
  function automatic logic [31:0] sat_mag(input logic [60:0] mag, input logic neg);
    logic [31:0] res;
    if (neg) begin
      res = (mag > 61'h0_8000_0000) ? 32'h8000_0000 : mag[31:0];
    end else begin
      res = (mag > 61'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    end
    return res;
  endfunction

  // One restoring division step: bring in the next dividend bit, shift in a quotient bit.
  function automatic logic [92:0] div_step(input logic [60:0] rem, input logic [31:0] qd,
                                           input logic [60:0] dvsr);
    logic [61:0] trial;
    logic [62:0] diff;
    logic        ge;
    logic [60:0] rem_o;
    trial = {rem, qd[31]};
    diff  = {1'b0, trial} - {2'b00, dvsr};
    ge    = ~diff[62];
    rem_o = ge ? diff[60:0] : trial[60:0];
    return {rem_o, qd[30:0], ge};
  endfunction

  // ---------------------------------------------------------------------------
  // Handshake: the whole pipeline advances unless the skid register is full.
  // ---------------------------------------------------------------------------
  assign en        = ~skid_vld_r;
  assign in_stall  = skid_vld_r;
  assign cfg_ready = 1'b1;
  assign vld_nxt   = {vld_r[ddws_pkg::NUM_STAGES-2:0], in_valid};

  // Park the output beat when it is stalled while the pipeline moves on.
  assign skid_load    = en & vld_r[LAST] & out_stall;
  assign skid_vld_nxt = skid_vld_r ? out_stall : skid_load;

  assign out_valid = skid_vld_r | vld_r[LAST];
  assign out_data  = skid_vld_r ? skid_r : so_r;

  // ---------------------------------------------------------------------------
  // Datapath, stage by stage.
  // ---------------------------------------------------------------------------

  // Stage 1: wz * track, exact in 64 bits.
  assign s1_turn_nxt = $signed(in_data.yaw_rate) * $signed({1'b0, track_r});

  // Stage 2: n = vx*2^17 -/+ turn; form both signs in parallel and keep the magnitude.
  assign s2_base  = {{15{s1_vx_r[31]}}, s1_vx_r, 17'd0};
  assign s2_l_pos = s2_base - s1_turn_r;
  assign s2_l_ngv = s1_turn_r - s2_base;
  assign s2_r_pos = s2_base + s1_turn_r;
  assign s2_r_ngv = 64'd0 - s2_base - s1_turn_r;
  assign s2_lmag_nxt = s2_l_pos[63] ? s2_l_ngv[62:0] : s2_l_pos[62:0];
  assign s2_rmag_nxt = s2_r_pos[63] ? s2_r_ngv[62:0] : s2_r_pos[62:0];

  // Stage 3: split the 63-bit magnitude into two halves for the radius product.
  assign s3_l_lo_nxt = 63'(s2_lmag_r[31:0]) * 63'(inv_r);
  assign s3_l_hi_nxt = 62'(s2_lmag_r[62:32]) * 62'(inv_r);
  assign s3_r_lo_nxt = 63'(s2_rmag_r[31:0]) * 63'(inv_r);
  assign s3_r_hi_nxt = 62'(s2_rmag_r[62:32]) * 62'(inv_r);

  // Stage 4: (hi*2^32 + lo) >> 33, as (hi + lo>>32) >> 1.
  assign s4_l_sum = s3_l_hi_r + 62'(s3_l_lo_r[62:32]);
  assign s4_r_sum = s3_r_hi_r + 62'(s3_r_lo_r[62:32]);

  // Stage 5: scale when either wheel exceeds a nonzero limit.
  assign s5_max61     = 61'(max_r);
  assign s5_scale_nxt = (max_r != '0) & ((s4_lmag_r > s5_max61) | (s4_rmag_r > s5_max61));
  assign s5_top_nxt   = (s4_lmag_r > s4_rmag_r) ? s4_lmag_r : s4_rmag_r;
  assign s5_l_plo_nxt = 63'(s4_lmag_r[31:0]) * 63'(max_r);
  assign s5_l_phi_nxt = 60'(s4_lmag_r[60:32]) * 60'(max_r);
  assign s5_r_plo_nxt = 63'(s4_rmag_r[31:0]) * 63'(max_r);
  assign s5_r_phi_nxt = 60'(s4_rmag_r[60:32]) * 60'(max_r);

  // Divider load: a scaled item divides |w|*max by the larger speed; an unscaled one
  // divides its clamped magnitude by one, so the same steps pass it through.
  assign dv_prod_l = {s5_l_phi_r, 32'd0} + 92'(s5_l_plo_r);
  assign dv_prod_r = {s5_r_phi_r, 32'd0} + 92'(s5_r_plo_r);
  assign dv_dend_l = s5_scale_r ? dv_prod_l : 92'(s5_l_sat_r);
  assign dv_dend_r = s5_scale_r ? dv_prod_r : 92'(s5_r_sat_r);

  always_comb begin
    dv_nxt[0].rem_l  = 61'(dv_dend_l[91:32]);
    dv_nxt[0].qd_l   = dv_dend_l[31:0];
    dv_nxt[0].rem_r  = 61'(dv_dend_r[91:32]);
    dv_nxt[0].qd_r   = dv_dend_r[31:0];
    dv_nxt[0].dvsr   = s5_scale_r ? s5_top_r : 61'd1;
    dv_nxt[0].neg_l  = s5_lneg_r;
    dv_nxt[0].neg_r  = s5_rneg_r;
    dv_nxt[0].scaled = s5_scale_r;
    for (int i = 1; i <= ddws_pkg::DIV_STEPS; i++) begin
      {dv_nxt[i].rem_l, dv_nxt[i].qd_l} = div_step(dv_r[i-1].rem_l, dv_r[i-1].qd_l,
                                                   dv_r[i-1].dvsr);
      {dv_nxt[i].rem_r, dv_nxt[i].qd_r} = div_step(dv_r[i-1].rem_r, dv_r[i-1].qd_r,
                                                   dv_r[i-1].dvsr);
      dv_nxt[i].dvsr   = dv_r[i-1].dvsr;
      dv_nxt[i].neg_l  = dv_r[i-1].neg_l;
      dv_nxt[i].neg_r  = dv_r[i-1].neg_r;
      dv_nxt[i].scaled = dv_r[i-1].scaled;
    end
  end

  // Output stage: restore the signs.
  always_comb begin
    so_nxt.left_wheel_speed  = dv_r[ddws_pkg::DIV_STEPS].neg_l ?
                               32'd0 - dv_r[ddws_pkg::DIV_STEPS].qd_l :
                               dv_r[ddws_pkg::DIV_STEPS].qd_l;
    so_nxt.right_wheel_speed = dv_r[ddws_pkg::DIV_STEPS].neg_r ?
                               32'd0 - dv_r[ddws_pkg::DIV_STEPS].qd_r :
                               dv_r[ddws_pkg::DIV_STEPS].qd_r;
    so_nxt.was_scaled        = dv_r[ddws_pkg::DIV_STEPS].scaled;
  end

  // ---------------------------------------------------------------------------
  // Registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= '0;
      skid_vld_r <= 1'b0;
      track_r    <= ddws_pkg::WHEEL_TRACK_RST;
      inv_r      <= ddws_pkg::INV_WHEEL_RADIUS_RST;
      max_r      <= ddws_pkg::MAX_WHEEL_SPEED_RST;
    end else begin
      skid_vld_r <= skid_vld_nxt;
      if (en) begin
        vld_r <= vld_nxt;
      end
      if (cfg_valid) begin
        case (cfg_index)
          ddws_pkg::CFG_WHEEL_TRACK:      track_r <= cfg_data;
          ddws_pkg::CFG_INV_WHEEL_RADIUS: inv_r   <= cfg_data;
          ddws_pkg::CFG_MAX_WHEEL_SPEED:  max_r   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_load) begin
      skid_r <= so_r;
    end
    if (en) begin
      s1_vx_r    <= in_data.forward_speed;
      s1_turn_r  <= s1_turn_nxt;
      s2_lmag_r  <= s2_lmag_nxt;
      s2_rmag_r  <= s2_rmag_nxt;
      s2_lneg_r  <= s2_l_pos[63];
      s2_rneg_r  <= s2_r_pos[63];
      s3_l_lo_r  <= s3_l_lo_nxt;
      s3_l_hi_r  <= s3_l_hi_nxt;
      s3_r_lo_r  <= s3_r_lo_nxt;
      s3_r_hi_r  <= s3_r_hi_nxt;
      s3_lneg_r  <= s2_lneg_r;
      s3_rneg_r  <= s2_rneg_r;
      s4_lmag_r  <= s4_l_sum[61:1];
      s4_rmag_r  <= s4_r_sum[61:1];
      s4_lneg_r  <= s3_lneg_r;
      s4_rneg_r  <= s3_rneg_r;
      s5_top_r   <= s5_top_nxt;
      s5_scale_r <= s5_scale_nxt;
      s5_l_sat_r <= sat_mag(s4_lmag_r, s4_lneg_r);
      s5_r_sat_r <= sat_mag(s4_rmag_r, s4_rneg_r);
      s5_l_plo_r <= s5_l_plo_nxt;
      s5_l_phi_r <= s5_l_phi_nxt;
      s5_r_plo_r <= s5_r_plo_nxt;
      s5_r_phi_r <= s5_r_phi_nxt;
      s5_lneg_r  <= s4_lneg_r;
      s5_rneg_r  <= s4_rneg_r;
      for (int i = 0; i <= ddws_pkg::DIV_STEPS; i++) begin
        dv_r[i] <= dv_nxt[i];
      end
      so_r <= so_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // The skid register only fills from a stalled output beat.
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_vld_r) |-> $past(vld_r[LAST] && out_stall))
    else $error("skid filled without a stalled output beat");

  // While a beat sits in the skid register the pipeline must hold.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |=> $stable(vld_r))
    else $error("pipeline moved while skid register was full");

  // Restoring division keeps the remainder below the divisor.
  a_rem: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[DV_LAST] |-> (dv_r[ddws_pkg::DIV_STEPS].rem_l < dv_r[ddws_pkg::DIV_STEPS].dvsr) &&
                       (dv_r[ddws_pkg::DIV_STEPS].rem_r < dv_r[ddws_pkg::DIV_STEPS].dvsr))
    else $error("divider remainder not below divisor");

  // Scaling only happens with a limit configured.
  a_scaled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.was_scaled |-> (max_r != '0))
    else $error("result scaled with no speed limit set");
`endif

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the differential-drive wheel speed block.
`timescale 1ns / 100ps

module tb;

  // Give up after this many cycles in a row with no beat moving on any channel.
  localparam int STALL_LIMIT = 4000;
  // Register index past the end of the register list; the block must ignore it.
  localparam logic [ddws_pkg::CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;

  logic clk;
  logic rst_n = 1'b0;

  // Command channel.
  logic                in_valid = 1'b0;
  logic                in_stall;
  ddws_pkg::in_beat_t  in_data  = '0;

  // Result channel.
  logic                out_valid;
  logic                out_stall = 1'b0;
  ddws_pkg::out_beat_t out_data;

  // Register write channel.
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [ddws_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [ddws_pkg::CFG_W-1:0]     cfg_data  = '0;

  // Register values as the block should hold them; they change only while it is idle.
  logic [ddws_pkg::CFG_W-1:0] track_q       = ddws_pkg::WHEEL_TRACK_RST;
  logic [ddws_pkg::CFG_W-1:0] inv_radius_q  = ddws_pkg::INV_WHEEL_RADIUS_RST;
  logic [ddws_pkg::CFG_W-1:0] speed_limit_q = ddws_pkg::MAX_WHEEL_SPEED_RST;

  ddws_pkg::in_beat_t  pending_cmds[$];    // commands not yet offered
  ddws_pkg::out_beat_t pending_speeds[$];  // wheel speeds owed by the block, oldest first
  ddws_pkg::out_beat_t want;

  int cmds_queued    = 0;
  int results_seen   = 0;
  int mismatches     = 0;
  int scaled_results = 0;
  int settings_used  = 1;
  int idle_cycles    = 0;

  // Pacing: the largest gap each side may draw per beat, and the long hold-off.
  int   in_gap_max  = 0;
  int   out_gap_max = 0;
  int   in_gap      = 0;
  int   stall_left  = 0;
  logic out_hold    = 1'b0;

  differential_drive_wheel_speeds DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Wheel speeds for one command under the current register values.
  // Linear terms live in units of 2^-33 m/s so that track/2 stays exact:
  // n = vx*2^17 -/+ wz*track, then w = n*inv_radius / 2^33 truncated toward zero.
  function automatic ddws_pkg::out_beat_t wheel_speeds_for(ddws_pkg::in_beat_t cmd);
    logic signed [63:0]  vx, wz, base, turn;
    logic [1:0][63:0]    lin, mag;
    logic [1:0][31:0]    field;
    logic [1:0]          neg;
    logic [127:0]        prod;
    logic [63:0]         top;
    ddws_pkg::out_beat_t res;
    vx   = {{32{cmd.forward_speed[31]}}, cmd.forward_speed};
    wz   = {{32{cmd.yaw_rate[31]}}, cmd.yaw_rate};
    base = vx <<< 17;
    turn = wz * $signed({33'd0, track_q});
    lin[0] = base - turn;
    lin[1] = base + turn;
    // Work on magnitudes so every truncation goes toward zero.
    for (int i = 0; i < 2; i++) begin
      neg[i] = lin[i][63];
      mag[i] = neg[i] ? -lin[i] : lin[i];
      prod   = {64'd0, mag[i]} * {97'd0, inv_radius_q};
      mag[i] = prod[96:33];
    end
    top = (mag[0] > mag[1]) ? mag[0] : mag[1];
    // Desaturate: scale both wheels by limit/top, exact product, truncated quotient.
    res.was_scaled = (speed_limit_q != '0) && (top > {33'd0, speed_limit_q});
    if (res.was_scaled) begin
      for (int i = 0; i < 2; i++) begin
        prod   = {64'd0, mag[i]} * {97'd0, speed_limit_q};
        prod   = prod / {64'd0, top};
        mag[i] = prod[63:0];
      end
    end
    // Clamp to the 32-bit signed range, then restore the sign.
    for (int i = 0; i < 2; i++) begin
      if (neg[i]) begin
        if (mag[i] > 64'h8000_0000) mag[i] = 64'h8000_0000;
        field[i] = ~mag[i][31:0] + 32'd1;
      end else begin
        if (mag[i] > 64'h7fff_ffff) mag[i] = 64'h7fff_ffff;
        field[i] = mag[i][31:0];
      end
    end
    res.left_wheel_speed  = field[0];
    res.right_wheel_speed = field[1];
    return res;
  endfunction

  // Corner speeds: extremes, zero, one LSB either way, +/-1.0, 0.5 and 2^14.
  function automatic logic [31:0] corner_speed(int k);
    case (k)
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'h0000_0001;
      4:       return 32'hffff_ffff;
      5:       return 32'h0001_0000;
      6:       return 32'hffff_0000;
      7:       return 32'h0000_8000;
      default: return 32'h4000_0000;
    endcase
  endfunction

  // Mix of full-range noise, realistic speeds within +/-10.0, corners and
  // values of every magnitude.
  function automatic logic [31:0] pick_speed();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return $urandom_range(0, 1310720) - 32'd655360;
      2:       return corner_speed($urandom_range(0, 8));
      default: return $signed($urandom) >>> $urandom_range(0, 30);
    endcase
  endfunction

  function automatic logic [ddws_pkg::CFG_W-1:0] pick_reg();
    case ($urandom_range(0, 4))
      0:       return 31'd1;
      1:       return 31'h7fff_ffff;
      2:       return 31'($urandom_range(6554, 1310720));
      3:       return 31'($urandom_range(1, 32'h7fff_ffff));
      default: return 31'($urandom_range(1, 65536 * 256));
    endcase
  endfunction

  task automatic add_cmd(input logic [31:0] vx, input logic [31:0] wz);
    ddws_pkg::in_beat_t cmd;
    cmd.forward_speed = vx;
    cmd.yaw_rate      = wz;
    pending_cmds.push_back(cmd);
    cmds_queued++;
  endtask

  // Every pairing of the range extremes and zero, then pairs of small corners.
  task automatic add_corner_cmds();
    for (int a = 0; a < 3; a++)
      for (int b = 0; b < 3; b++)
        add_cmd(corner_speed(a), corner_speed(b));
    for (int k = 3; k < 9; k++) begin
      add_cmd(corner_speed(k), corner_speed(k % 6 + 3));
      add_cmd(corner_speed(k), corner_speed(11 - k));
    end
  endtask

  task automatic add_random_cmds(input int n);
    for (int i = 0; i < n; i++)
      add_cmd(pick_speed(), pick_speed());
  endtask

  // Hold a register write until it is taken; leave cfg_valid high for the caller.
  task automatic cfg_write(input logic [ddws_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ddws_pkg::CFG_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      ddws_pkg::CFG_WHEEL_TRACK:      track_q       = val;
      ddws_pkg::CFG_INV_WHEEL_RADIUS: inv_radius_q  = val;
      ddws_pkg::CFG_MAX_WHEEL_SPEED:  speed_limit_q = val;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [ddws_pkg::CFG_W-1:0] track,
                           input logic [ddws_pkg::CFG_W-1:0] inv,
                           input logic [ddws_pkg::CFG_W-1:0] limit);
    cfg_write(ddws_pkg::CFG_WHEEL_TRACK, track);
    cfg_write(ddws_pkg::CFG_INV_WHEEL_RADIUS, inv);
    cfg_write(ddws_pkg::CFG_MAX_WHEEL_SPEED, limit);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic set_pacing(input int in_max, input int out_max);
    in_gap_max  <= in_max;
    out_gap_max <= out_max;
  endtask

  // Wait until every queued command has come back as a result.
  task automatic wait_drained();
    while (results_seen < cmds_queued) @(posedge clk);
  endtask

  // Driver: offer queued commands, hold a stalled beat, idle a drawn number
  // of cycles between beats.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else begin
      if (in_valid && !in_stall)
        pending_speeds.push_back(wheel_speeds_for(in_data));
      if (!in_valid || !in_stall) begin
        if (in_gap != 0) begin
          in_valid <= 1'b0;
          in_gap   <= in_gap - 1;
        end else if (pending_cmds.size() != 0) begin
          in_data  <= pending_cmds.pop_front();
          in_valid <= 1'b1;
          in_gap   <= $urandom_range(0, in_gap_max);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each taken result field by field against the oldest
  // expectation, then draw how long to stall before the next one.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (pending_speeds.size() == 0) begin
          $display("%0t: result with nothing expected: left %0d right %0d scaled %0b", $time,
                   $signed(out_data.left_wheel_speed), $signed(out_data.right_wheel_speed),
                   out_data.was_scaled);
          mismatches++;
        end else begin
          want = pending_speeds.pop_front();
          if (want.was_scaled) scaled_results++;
          if (out_data.left_wheel_speed !== want.left_wheel_speed) begin
            $display("%0t: left_wheel_speed expected %0d, got %0d", $time,
                     $signed(want.left_wheel_speed), $signed(out_data.left_wheel_speed));
            mismatches++;
          end
          if (out_data.right_wheel_speed !== want.right_wheel_speed) begin
            $display("%0t: right_wheel_speed expected %0d, got %0d", $time,
                     $signed(want.right_wheel_speed), $signed(out_data.right_wheel_speed));
            mismatches++;
          end
          if (out_data.was_scaled !== want.was_scaled) begin
            $display("%0t: was_scaled expected %0b, got %0b", $time,
                     want.was_scaled, out_data.was_scaled);
            mismatches++;
          end
        end
        stall_left = $urandom_range(0, out_gap_max);
      end
      if (out_hold) begin
        out_stall <= 1'b1;
      end else if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Count cycles in which no beat moves on any channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
    $display("** differential_drive_wheel_speeds: FAILED **");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset values (unit track and radius, no limit): corners overflow and clamp.
    add_corner_cmds();
    add_random_cmds(150);
    wait_drained();

    // Small robot: 0.3 m track, 0.05 m wheels, 10 rad/s limit; full idling.
    configure(31'd19661, 31'd1310720, 31'd655360);
    set_pacing(6, 6);
    add_corner_cmds();
    add_random_cmds(300);
    wait_drained();

    // Every register at its top value.
    configure(31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff);
    set_pacing(3, 0);
    add_corner_cmds();
    add_random_cmds(150);
    wait_drained();

    // Every register at one LSB: nearly everything hits the limit.
    configure(31'd1, 31'd1, 31'd1);
    set_pacing(0, 4);
    add_corner_cmds();
    add_random_cmds(150);
    wait_drained();

    // Zero track and zero reciprocal radius; also poke an index past the list.
    cfg_write(CFG_NO_REG, 31'h7fff_ffff);
    configure(31'd0, 31'd0, 31'd0);
    set_pacing(2, 2);
    add_corner_cmds();
    add_random_cmds(40);
    wait_drained();

    // Back pressure: hold the result side off long enough for the pipeline
    // and its skid register to fill while commands keep coming.
    configure(31'd32768, 31'd655360, 31'd983040);
    set_pacing(0, 0);
    out_hold <= 1'b1;
    add_random_cmds(150);
    repeat (200) @(posedge clk);
    out_hold <= 1'b0;
    wait_drained();

    // Random settings, with and without idling on each side.
    for (int p = 0; p < 7; p++) begin
      configure(pick_reg(), pick_reg(), ($urandom_range(0, 3) == 0) ? 31'd0 : pick_reg());
      set_pacing($urandom_range(0, 1) * 6, $urandom_range(0, 1) * 6);
      add_random_cmds(130);
      wait_drained();
    end

    // Let any stray result surface before judging.
    repeat (ddws_pkg::NUM_STAGES + 8) @(posedge clk);
    $display("tb: %0d commands checked under %0d register settings",
             results_seen, settings_used);
    $display("tb: %0d results were scaled to the wheel speed limit", scaled_results);
    if (mismatches == 0 && pending_speeds.size() == 0) begin
      $display("** differential_drive_wheel_speeds: PASSED **");
    end else begin
      $display("tb: %0d mismatches, %0d results never arrived",
               mismatches, pending_speeds.size());
      $display("** differential_drive_wheel_speeds: FAILED **");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/ddws_pkg.sv
src/differential_drive_wheel_speeds.sv
tb/tb.sv
